// ===== rtl/awb_pkg.sv =====
// Shared types and constants for the AWB gain block.
// No dependencies; used by awb_gain_sel, awb_wr_ser, the top level and the bench.
package awb_pkg;

    localparam int DATA_W     = 16;
    // 512 * typical: 16 + 9 bits
    localparam int DIV1_NUM_W = 25;
    // 256 * ratio and 256 * 512 both fit in 24 bits
    localparam int DIV2_NUM_W = 24;

    localparam logic [DATA_W-1:0]     GAIN_UNITY = 16'h0100;
    localparam logic [DATA_W-1:0]     RATIO_ONE  = 16'd512;
    localparam logic [DIV2_NUM_W-1:0] UNITY_NUM  = 24'h02_0000;  // 256 * 512

    localparam logic [DATA_W-1:0] ADDR_GREEN1 = 16'h020E;
    localparam logic [DATA_W-1:0] ADDR_RED    = 16'h0210;
    localparam logic [DATA_W-1:0] ADDR_BLUE   = 16'h0212;
    localparam logic [DATA_W-1:0] ADDR_GREEN2 = 16'h0214;

    // write order: two byte writes per slot
    localparam logic [1:0] SLOT_RED    = 2'd0;
    localparam logic [1:0] SLOT_BLUE   = 2'd1;
    localparam logic [1:0] SLOT_GREEN1 = 2'd2;
    localparam logic [1:0] SLOT_GREEN2 = 2'd3;

    localparam logic [2:0] LAST_WRITE = 3'd7;

    typedef struct packed {
        logic              rej;
        logic [DATA_W-1:0] red;
        logic [DATA_W-1:0] green;
        logic [DATA_W-1:0] blue;
    } t_gains;

endpackage

// ===== rtl/awb_div_pipe.sv =====
// Pipelined restoring divider, STEP quotient bits per register stage.
// Standalone; carries a tag and a valid bit alongside each quotient.
module awb_div_pipe #(
    parameter int NUM_W = 25,
    parameter int DEN_W = 16,
    parameter int TAG_W = 1,
    parameter int STEP  = 2      // 1..8; needs at least two stages
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_quo,
    output logic [TAG_W-1:0] o_tag
);

    localparam int NS = (NUM_W + STEP - 1) / STEP;
    localparam int PW = NS * STEP;

    // numerator bits shift out at the top while quotient bits shift in below
    logic             r_vld [NS];
    logic [PW-1:0]    r_nq  [NS];
    logic [DEN_W-1:0] r_den [NS];
    logic [TAG_W-1:0] r_tag [NS];
    logic [DEN_W-1:0] r_rem [NS-1];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic             vld_in;
        logic [PW-1:0]    nq_in;
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [TAG_W-1:0] tag_in;
        logic [PW-1:0]    n_nq;
        logic [DEN_W-1:0] n_rem;

        if (s == 0) begin : g_first
            assign vld_in = i_valid;
            assign nq_in  = PW'(i_num);
            assign rem_in = '0;
            assign den_in = i_den;
            assign tag_in = i_tag;
        end else begin : g_next
            assign vld_in = r_vld[s-1];
            assign nq_in  = r_nq[s-1];
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
            assign tag_in = r_tag[s-1];
        end

        always_comb begin
            logic [DEN_W:0]   ext;
            logic [DEN_W-1:0] rem;
            logic [PW-1:0]    nq;
            rem = rem_in;
            nq  = nq_in;
            ext = '0;
            for (int k = 0; k < STEP; k++) begin
                ext = {rem, nq[PW-1]};
                nq  = {nq[PW-2:0], 1'b0};
                if (ext >= {1'b0, den_in}) begin
                    ext   = ext - {1'b0, den_in};
                    nq[0] = 1'b1;
                end
                rem = ext[DEN_W-1:0];
            end
            n_nq  = nq;
            n_rem = rem;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nq[s]  <= n_nq;
                r_den[s] <= den_in;
                r_tag[s] <= tag_in;
            end
        end

        // the last stage's remainder is not needed
        if (s < NS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= n_rem;
                end
            end
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_quo   = r_nq[NS-1][NUM_W-1:0];
    assign o_tag   = r_tag[NS-1];

endmodule

// ===== rtl/awb_gain_sel.sv =====
// Gain selection stage: picks R/G/B gains so the smallest is unity.
// Depends on awb_pkg; fed by the second divider bank.
module awb_gain_sel (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic                        i_rej,
    input  logic [awb_pkg::DATA_W-1:0]  i_r,
    input  logic [awb_pkg::DATA_W-1:0]  i_b,
    input  logic [awb_pkg::DATA_W-1:0]  i_gr,   // 256*512/r, wrapped
    input  logic [awb_pkg::DATA_W-1:0]  i_gb,   // 256*512/b, wrapped
    input  logic [awb_pkg::DATA_W-1:0]  i_br,   // 256*b/r, wrapped
    input  logic [awb_pkg::DATA_W-1:0]  i_rb,   // 256*r/b, wrapped
    output logic                        o_vld,
    output awb_pkg::t_gains             o_gains
);

    logic            r_vld;
    awb_pkg::t_gains r_gains;
    awb_pkg::t_gains n_gains;
    logic            ge_r;
    logic            ge_b;
    logic            use_red;

    assign ge_r    = (i_r >= awb_pkg::RATIO_ONE);
    assign ge_b    = (i_b >= awb_pkg::RATIO_ONE);
    // with both ratios low, the truncated green candidates decide
    assign use_red = !ge_r && (ge_b || (i_gr >= i_gb));

    always_comb begin
        n_gains.rej = i_rej;
        if (ge_r && ge_b) begin
            n_gains.red   = {1'b0, i_r[awb_pkg::DATA_W-1:1]};
            n_gains.green = awb_pkg::GAIN_UNITY;
            n_gains.blue  = {1'b0, i_b[awb_pkg::DATA_W-1:1]};
        end else if (use_red) begin
            n_gains.red   = awb_pkg::GAIN_UNITY;
            n_gains.green = i_gr;
            n_gains.blue  = i_br;
        end else begin
            n_gains.red   = i_rb;
            n_gains.green = i_gb;
            n_gains.blue  = awb_pkg::GAIN_UNITY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_gains <= n_gains;
        end
    end

    assign o_vld   = r_vld;
    assign o_gains = r_gains;

endmodule

// ===== rtl/awb_wr_ser.sv =====
// Output register and serializer: one gain set into eight byte writes, or one status write if rejected.
// Depends on awb_pkg; drives the result channel of the top level.
module awb_wr_ser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  awb_pkg::t_gains            i_gains,
    output logic                       o_load_ok,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [awb_pkg::DATA_W-1:0] o_reg_address,
    output logic [7:0]                 o_reg_byte,
    output logic                       o_status,
    output logic                       o_last
);

    logic                       r_vld;
    logic [2:0]                 r_cnt;
    awb_pkg::t_gains            r_g;
    logic                       last;
    logic                       take;
    logic [awb_pkg::DATA_W-1:0] base;
    logic [awb_pkg::DATA_W-1:0] gain;

    assign last      = r_g.rej || (r_cnt == awb_pkg::LAST_WRITE);
    assign take      = r_vld && i_ready;
    assign o_load_ok = !r_vld || (i_ready && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_cnt <= '0;
        end else if (o_load_ok) begin
            r_vld <= i_vld;
            r_cnt <= '0;
        end else if (take) begin
            r_cnt <= r_cnt + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load_ok && i_vld) begin
            r_g <= i_gains;
        end
    end

    always_comb begin
        case (r_cnt[2:1])
            awb_pkg::SLOT_RED: begin
                base = awb_pkg::ADDR_RED;
                gain = r_g.red;
            end
            awb_pkg::SLOT_BLUE: begin
                base = awb_pkg::ADDR_BLUE;
                gain = r_g.blue;
            end
            awb_pkg::SLOT_GREEN1: begin
                base = awb_pkg::ADDR_GREEN1;
                gain = r_g.green;
            end
            awb_pkg::SLOT_GREEN2: begin
                base = awb_pkg::ADDR_GREEN2;
                gain = r_g.green;
            end
            default: begin
                base = '0;
                gain = '0;
            end
        endcase
    end

    // base addresses are even: low byte goes to base + 1
    assign o_valid       = r_vld;
    assign o_reg_address = r_g.rej ? '0 : (base | awb_pkg::DATA_W'(r_cnt[0]));
    assign o_reg_byte    = r_g.rej ? 8'h00 : (r_cnt[0] ? gain[7:0] : gain[15:8]);
    assign o_status      = r_g.rej;
    assign o_last        = last;

    a_rej_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_last)
        else $error("rejected item must be a single transfer");

    a_burst_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> o_valid && !o_status)
        else $error("write burst broken before its last transfer");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

// ===== rtl/awb_gain_from_ratios_top.sv =====
// Top level: AWB gains from measured and golden R/G, B/G ratios.
// Depends on awb_pkg, awb_div_pipe, awb_gain_sel, awb_wr_ser.
//
//  Channel  Dir  Handshake                   Payload
//  in       in   i_in_valid / o_in_ready     i_rg_measured i_bg_measured
//                                            i_rg_typical i_bg_typical
//  out      out  o_out_valid / i_out_ready   o_reg_address o_reg_byte
//                                            o_status o_last
//
// The first transfer follows the ratio divider bank, the ratio register, the gain divider
// bank, the gain stage register and the serializer's output register.
// The byte serializer sets the rate: eight transfers per item, one for a rejected item.
// Reset is synchronous, active low, and clears all valid bits.
// A held output stalls the whole pipe in place once the gain stage is full.
module awb_gain_from_ratios_top #(
    parameter int DIV_STEP = 2     // quotient bits per divider stage, 1..8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [awb_pkg::DATA_W-1:0] i_rg_measured,
    input  logic [awb_pkg::DATA_W-1:0] i_bg_measured,
    input  logic [awb_pkg::DATA_W-1:0] i_rg_typical,
    input  logic [awb_pkg::DATA_W-1:0] i_bg_typical,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [awb_pkg::DATA_W-1:0] o_reg_address,
    output logic [7:0]                 o_reg_byte,
    output logic                       o_status,
    output logic                       o_last
);

    localparam int DW  = awb_pkg::DATA_W;
    localparam int N1W = awb_pkg::DIV1_NUM_W;
    localparam int N2W = awb_pkg::DIV2_NUM_W;

    logic en;
    logic in_zero;

    logic           d1r_vld, d1b_vld;
    logic [N1W-1:0] d1r_quo, d1b_quo;
    logic           d1r_tag, d1b_tag;

    logic          r_m_vld;
    logic [DW-1:0] r_m_r;
    logic [DW-1:0] r_m_b;
    logic          r_m_rej;

    logic           d2gr_vld, d2gb_vld, d2br_vld, d2rb_vld;
    logic [N2W-1:0] d2gr_quo, d2gb_quo, d2br_quo, d2rb_quo;
    logic [2*DW:0]  d2gr_tag;
    logic           d2gb_tag, d2br_tag, d2rb_tag;

    logic            sel_vld;
    awb_pkg::t_gains sel_gains;
    logic            ser_load_ok;

    // the pipe advances unless the gain stage holds an item the serializer cannot take
    assign en         = !sel_vld || ser_load_ok;
    assign o_in_ready = en;
    assign in_zero    = (i_rg_measured == '0) || (i_bg_measured == '0) ||
                        (i_rg_typical == '0) || (i_bg_typical == '0);

    // r = 512 * rg_typical / rg_measured, b likewise
    awb_div_pipe #(.NUM_W(N1W), .DEN_W(DW), .TAG_W(1), .STEP(DIV_STEP)) u_div_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_in_valid),
        .i_num({i_rg_typical, 9'h000}), .i_den(i_rg_measured), .i_tag(in_zero),
        .o_valid(d1r_vld), .o_quo(d1r_quo), .o_tag(d1r_tag)
    );

    awb_div_pipe #(.NUM_W(N1W), .DEN_W(DW), .TAG_W(1), .STEP(DIV_STEP)) u_div_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_in_valid),
        .i_num({i_bg_typical, 9'h000}), .i_den(i_bg_measured), .i_tag(in_zero),
        .o_valid(d1b_vld), .o_quo(d1b_quo), .o_tag(d1b_tag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (en) begin
            r_m_vld <= d1r_vld && d1b_vld;
        end
    end

    // wrapped ratio of zero is rejected too
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_r   <= d1r_quo[DW-1:0];
            r_m_b   <= d1b_quo[DW-1:0];
            r_m_rej <= d1r_tag || d1b_tag ||
                       (d1r_quo[DW-1:0] == '0) || (d1b_quo[DW-1:0] == '0);
        end
    end

    awb_div_pipe #(.NUM_W(N2W), .DEN_W(DW), .TAG_W(2*DW+1), .STEP(DIV_STEP)) u_div_gr (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_m_vld),
        .i_num(awb_pkg::UNITY_NUM), .i_den(r_m_r), .i_tag({r_m_rej, r_m_r, r_m_b}),
        .o_valid(d2gr_vld), .o_quo(d2gr_quo), .o_tag(d2gr_tag)
    );

    awb_div_pipe #(.NUM_W(N2W), .DEN_W(DW), .TAG_W(1), .STEP(DIV_STEP)) u_div_gb (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_m_vld),
        .i_num(awb_pkg::UNITY_NUM), .i_den(r_m_b), .i_tag(r_m_rej),
        .o_valid(d2gb_vld), .o_quo(d2gb_quo), .o_tag(d2gb_tag)
    );

    awb_div_pipe #(.NUM_W(N2W), .DEN_W(DW), .TAG_W(1), .STEP(DIV_STEP)) u_div_br (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_m_vld),
        .i_num({r_m_b, 8'h00}), .i_den(r_m_r), .i_tag(r_m_rej),
        .o_valid(d2br_vld), .o_quo(d2br_quo), .o_tag(d2br_tag)
    );

    awb_div_pipe #(.NUM_W(N2W), .DEN_W(DW), .TAG_W(1), .STEP(DIV_STEP)) u_div_rb (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_m_vld),
        .i_num({r_m_r, 8'h00}), .i_den(r_m_b), .i_tag(r_m_rej),
        .o_valid(d2rb_vld), .o_quo(d2rb_quo), .o_tag(d2rb_tag)
    );

    awb_gain_sel u_sel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (d2gr_vld && d2gb_vld && d2br_vld && d2rb_vld),
        .i_rej   (d2gr_tag[2*DW] || d2gb_tag || d2br_tag || d2rb_tag),
        .i_r     (d2gr_tag[2*DW-1:DW]),
        .i_b     (d2gr_tag[DW-1:0]),
        .i_gr    (d2gr_quo[DW-1:0]),
        .i_gb    (d2gb_quo[DW-1:0]),
        .i_br    (d2br_quo[DW-1:0]),
        .i_rb    (d2rb_quo[DW-1:0]),
        .o_vld   (sel_vld),
        .o_gains (sel_gains)
    );

    awb_wr_ser u_ser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (sel_vld),
        .i_gains       (sel_gains),
        .o_load_ok     (ser_load_ok),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_reg_address (o_reg_address),
        .o_reg_byte    (o_reg_byte),
        .o_status      (o_status),
        .o_last        (o_last)
    );

    a_ratio_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d1r_vld == d1b_vld)
        else $error("ratio dividers out of lockstep");

    a_gain_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (d2gr_vld == d2gb_vld) && (d2gr_vld == d2br_vld) && (d2gr_vld == d2rb_vld))
        else $error("gain dividers out of lockstep");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(sel_gains) && sel_vld)
        else $error("gain stage changed during a stall");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for awb_gain_from_ratios_top: directed and random ratio transfers,
// gains predicted in-bench and compared per register byte write.
// Depends on awb_pkg and the sources under rtl/.
module testbench;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;

    localparam logic [31:0] RATIO_ONE_W = 32'(awb_pkg::RATIO_ONE);
    localparam logic [31:0] UNITY_W     = 32'(awb_pkg::GAIN_UNITY);

    typedef struct packed {
        logic [awb_pkg::DATA_W-1:0] addr;
        logic [7:0]                 data;
        logic                       status;
        logic                       last;
    } t_reg_write;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_MOSTLY} t_rx_mode;

    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       i_in_valid    = 1'b0;
    logic                       o_in_ready;
    logic [awb_pkg::DATA_W-1:0] i_rg_measured = '0;
    logic [awb_pkg::DATA_W-1:0] i_bg_measured = '0;
    logic [awb_pkg::DATA_W-1:0] i_rg_typical  = '0;
    logic [awb_pkg::DATA_W-1:0] i_bg_typical  = '0;
    logic                       o_out_valid;
    logic                       i_out_ready   = 1'b0;
    logic [awb_pkg::DATA_W-1:0] o_reg_address;
    logic [7:0]                 o_reg_byte;
    logic                       o_status;
    logic                       o_last;

    t_reg_write expected_writes[$];

    int mismatch_count = 0;
    int writes_checked = 0;
    int items_sent     = 0;
    int items_rejected = 0;
    int cycle_count    = 0;
    int burst_left     = 0;

    // long output hold: requests counted here, serviced by the receiver process
    int       hold_reqs    = 0;
    int       hold_seen    = 0;
    int       hold_left    = 0;
    t_rx_mode rx_mode      = RX_OPEN;
    int       rx_mode_left = 0;

    awb_gain_from_ratios_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_rg_measured (i_rg_measured),
        .i_bg_measured (i_bg_measured),
        .i_rg_typical  (i_rg_typical),
        .i_bg_typical  (i_bg_typical),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_reg_address (o_reg_address),
        .o_reg_byte    (o_reg_byte),
        .o_status      (o_status),
        .o_last        (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles, %0d writes outstanding",
                     cycle_count, expected_writes.size());
            $display("awb_gain_from_ratios_top verification failed");
            $finish;
        end
    end

    // Expected byte writes for one ratio item: one reject, or eight gain bytes.
    task automatic predict_gain_writes(input logic [15:0] rgm, bgm, rgt, bgt);
        logic [31:0]                r, b, gr, gb;
        logic [31:0]                gain_r, gain_g, gain_b;
        logic                       use_red;
        logic [awb_pkg::DATA_W-1:0] slot_addr [4];
        logic [awb_pkg::DATA_W-1:0] slot_gain [4];
        t_reg_write                 wr;
        r = '0;
        b = '0;
        if (rgm != 0 && bgm != 0 && rgt != 0 && bgt != 0) begin
            r = ((RATIO_ONE_W * rgt) / rgm) & 32'hFFFF;
            b = ((RATIO_ONE_W * bgt) / bgm) & 32'hFFFF;
        end
        if (r == 0 || b == 0) begin
            wr.addr   = '0;
            wr.data   = '0;
            wr.status = 1'b1;
            wr.last   = 1'b1;
            expected_writes.push_back(wr);
            items_rejected++;
        end else begin
            if (r >= RATIO_ONE_W && b >= RATIO_ONE_W) begin
                gain_r = (UNITY_W * r) / RATIO_ONE_W;
                gain_g = UNITY_W;
                gain_b = (UNITY_W * b) / RATIO_ONE_W;
            end else begin
                if (r >= RATIO_ONE_W) begin
                    use_red = 1'b0;
                end else if (b >= RATIO_ONE_W) begin
                    use_red = 1'b1;
                end else begin
                    // compare green candidates after 16-bit truncation
                    gr = ((UNITY_W * RATIO_ONE_W) / r) & 32'hFFFF;
                    gb = ((UNITY_W * RATIO_ONE_W) / b) & 32'hFFFF;
                    use_red = (gr >= gb);
                end
                if (use_red) begin
                    gain_r = UNITY_W;
                    gain_g = (UNITY_W * RATIO_ONE_W) / r;
                    gain_b = (UNITY_W * b) / r;
                end else begin
                    gain_r = (UNITY_W * r) / b;
                    gain_g = (UNITY_W * RATIO_ONE_W) / b;
                    gain_b = UNITY_W;
                end
            end
            slot_addr[awb_pkg::SLOT_RED]    = awb_pkg::ADDR_RED;
            slot_addr[awb_pkg::SLOT_BLUE]   = awb_pkg::ADDR_BLUE;
            slot_addr[awb_pkg::SLOT_GREEN1] = awb_pkg::ADDR_GREEN1;
            slot_addr[awb_pkg::SLOT_GREEN2] = awb_pkg::ADDR_GREEN2;
            slot_gain[awb_pkg::SLOT_RED]    = gain_r[15:0];
            slot_gain[awb_pkg::SLOT_BLUE]   = gain_b[15:0];
            slot_gain[awb_pkg::SLOT_GREEN1] = gain_g[15:0];
            slot_gain[awb_pkg::SLOT_GREEN2] = gain_g[15:0];
            for (int i = 0; i < 4; i++) begin
                wr.addr   = slot_addr[i];
                wr.data   = slot_gain[i][15:8];
                wr.status = 1'b0;
                wr.last   = 1'b0;
                expected_writes.push_back(wr);
                wr.addr   = slot_addr[i] + 16'd1;
                wr.data   = slot_gain[i][7:0];
                wr.last   = (i == awb_pkg::SLOT_GREEN2);
                expected_writes.push_back(wr);
            end
        end
    endtask

    // Sender: bursts of random length with random gaps, unless gaps are disabled.
    task automatic send_ratios(input logic [15:0] rgm, bgm, rgt, bgt, input bit allow_gap);
        int gap;
        gap = 0;
        if (allow_gap) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 12);
                burst_left = $urandom_range(1, 10);
            end
            burst_left--;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_rg_measured <= rgm;
        i_bg_measured <= bgm;
        i_rg_typical  <= rgt;
        i_bg_typical  <= bgt;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_gain_writes(rgm, bgm, rgt, bgt);
        items_sent++;
    endtask

    function automatic logic [15:0] rand_measured();
        if ($urandom_range(0, 4) == 0)
            return 16'($urandom_range(1, 65535));
        return 16'($urandom_range(16, 4000));
    endfunction

    // golden value placing the ratio roughly between 0.19x and 5x of unity
    function automatic logic [15:0] typical_for(input logic [15:0] meas);
        logic [31:0] t;
        t = (32'(meas) * $urandom_range(96, 2560)) >> 9;
        if (t == 0)
            t = 1;
        if (t > 32'hFFFF)
            t = 32'hFFFF;
        return t[15:0];
    endfunction

    // Receiver: ready pattern switches at random among four modes; a requested long hold overrides it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (hold_reqs != hold_seen) begin
            hold_seen   <= hold_reqs;
            hold_left   <= LONG_HOLD;
            i_out_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= t_rx_mode'($urandom_range(0, 3));
                rx_mode_left <= $urandom_range(16, 96);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                RX_OPEN:   i_out_ready <= 1'b1;
                RX_RANDOM: i_out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
                default:   i_out_ready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    // Result checker: every output transfer against the oldest expected write.
    always @(posedge i_clk) begin
        t_reg_write exp_wr;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            writes_checked++;
            if (expected_writes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("ERROR: unexpected write addr=%h byte=%h status=%b last=%b",
                             o_reg_address, o_reg_byte, o_status, o_last);
            end else begin
                exp_wr = expected_writes.pop_front();
                if (o_reg_address !== exp_wr.addr || o_reg_byte !== exp_wr.data ||
                    o_status !== exp_wr.status || o_last !== exp_wr.last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"ERROR: write %0d exp addr=%h byte=%h status=%b last=%b,",
                                  " got addr=%h byte=%h status=%b last=%b"},
                                 writes_checked, exp_wr.addr, exp_wr.data, exp_wr.status,
                                 exp_wr.last, o_reg_address, o_reg_byte, o_status, o_last);
                end
            end
        end
    end

    task automatic test_rejected_inputs();
        send_ratios(16'd0, 16'd300, 16'd400, 16'd500, 1'b1);
        send_ratios(16'd300, 16'd0, 16'd400, 16'd500, 1'b1);
        send_ratios(16'd300, 16'd400, 16'd0, 16'd500, 1'b1);
        send_ratios(16'd300, 16'd400, 16'd500, 16'd0, 1'b1);
        // ratio truncates to zero
        send_ratios(16'hFFFF, 16'd100, 16'd1, 16'd100, 1'b1);
        send_ratios(16'd100, 16'd1000, 16'd100, 16'd1, 1'b1);
        // 512 * 128 / 1 wraps to zero
        send_ratios(16'd1, 16'd100, 16'd128, 16'd100, 1'b1);
    endtask

    task automatic test_gain_regions();
        send_ratios(16'd400, 16'd300, 16'd500, 16'd600, 1'b1);   // both ratios above unity
        send_ratios(16'd100, 16'd200, 16'd200, 16'd100, 1'b1);   // red high, blue low
        send_ratios(16'd200, 16'd100, 16'd100, 16'd200, 1'b1);   // red low, blue high
        send_ratios(16'd400, 16'd200, 16'd100, 16'd150, 1'b1);   // both low, red smaller
        send_ratios(16'd200, 16'd400, 16'd150, 16'd100, 1'b1);   // both low, blue smaller
        send_ratios(16'd200, 16'd200, 16'd100, 16'd100, 1'b1);   // both low, equal
        send_ratios(16'd1000, 16'd512, 16'd1000, 16'd511, 1'b1); // red exactly unity
    endtask

    task automatic test_wrapped_values();
        // green candidate for r = 1 truncates to zero, so blue path wins
        send_ratios(16'd512, 16'd512, 16'd1, 16'd5, 1'b1);
        // r = 51200, b = 1: red and green gains wrap
        send_ratios(16'd1, 16'd512, 16'd100, 16'd1, 1'b1);
        // r wraps to 65024
        send_ratios(16'd1, 16'd7, 16'hFFFF, 16'd7, 1'b1);
        send_ratios(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_ratios(16'd1, 16'd1, 16'd1, 16'd1, 1'b1);
        send_ratios(16'hFFFF, 16'h5555, 16'hAAAA, 16'hFFFF, 1'b1);
    endtask

    // Output held off for a long stretch while input keeps coming back to back;
    // more items than the pipe holds, so the input stalls.
    task automatic test_output_backpressure();
        logic [15:0] rgm, bgm;
        hold_reqs <= hold_reqs + 1;
        for (int n = 0; n < 40; n++) begin
            rgm = rand_measured();
            bgm = rand_measured();
            send_ratios(rgm, bgm, typical_for(rgm), typical_for(bgm), 1'b0);
        end
    endtask

    task automatic test_random_mix(input int count);
        logic [15:0] f [4];
        int          sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                f[0] = rand_measured();
                f[1] = rand_measured();
                f[2] = typical_for(f[0]);
                f[3] = typical_for(f[1]);
            end else if (sel < 93) begin
                for (int k = 0; k < 4; k++)
                    f[k] = 16'($urandom_range(0, 65535));
                if (sel >= 85)
                    f[2'($urandom_range(0, 3))] = '0;
            end else begin
                // tiny ratios: zero and wrapped green candidates
                f[0] = 16'($urandom_range(512, 2048));
                f[1] = 16'($urandom_range(512, 2048));
                f[2] = 16'($urandom_range(1, 4));
                f[3] = 16'($urandom_range(1, 4));
            end
            // one stretch without input gaps
            send_ratios(f[0], f[1], f[2], f[3], !(n >= 40 && n < 60));
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_rejected_inputs();
        test_gain_regions();
        test_wrapped_values();
        test_output_backpressure();
        test_random_mix(75);
        i_in_valid <= 1'b0;
        while (expected_writes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display({"Summary: %0d ratio items sent (%0d rejected), gain regions, wraps",
                  " and a %0d-cycle output hold"},
                 items_sent, items_rejected, LONG_HOLD);
        $display("Summary: %0d byte writes checked, %0d mismatches, %0d cycles",
                 writes_checked, mismatch_count, cycle_count);
        if (mismatch_count == 0 && expected_writes.size() == 0)
            $display("awb_gain_from_ratios_top verification clean");
        else
            $display("awb_gain_from_ratios_top verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/awb_pkg.sv
rtl/awb_div_pipe.sv
rtl/awb_gain_sel.sv
rtl/awb_wr_ser.sv
rtl/awb_gain_from_ratios_top.sv
bench/testbench.sv
